// ===== design/swpr_pkg.sv =====
// Package for the stop-and-wait packet receiver.
// Holds the field widths, codes, header offsets and the shared structs.
// No dependencies.
package swpr_pkg;

   localparam int DEFAULT_MAX_PACKET_BYTES = 1024;

   localparam int BYTE_W = 8;
   localparam int STATUS_W = 3;
   localparam int LEN_W = 10;
   localparam int KIND_W = 2;
   localparam int BIT_SEL_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int STEP_W = 4;
   localparam int RSP_DATA_W = 24;

   // Header layout, byte offsets
   localparam int FLAGS_END = 2;
   localparam int CHECK_END = 4;
   localparam int HDR_BYTES = 8;

   // Ack packet constants
   localparam logic [BYTE_W-1:0] ACK_CHECK_FIX = 8'd8;
   localparam logic [BYTE_W-1:0] ACK_SIZE_LOW = 8'd8;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK = 2'd2;

   // Verdict codes
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_DATA = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_CHECKSUM = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_FLAG_BIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEQ_FLAG_BIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_FLAG_BIT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ACKNO_FLAG_BIT = 2'd3;

   localparam logic [BIT_SEL_W-1:0] RST_DATA_FLAG_BIT = 4'd15;
   localparam logic [BIT_SEL_W-1:0] RST_SEQ_FLAG_BIT = 4'd7;
   localparam logic [BIT_SEL_W-1:0] RST_ACK_FLAG_BIT = 4'd8;
   localparam logic [BIT_SEL_W-1:0] RST_ACKNO_FLAG_BIT = 4'd0;

   // Emit sequence: payload, verdict, then eight ack bytes
   localparam logic [STEP_W-1:0] STEP_PAYLOAD = 4'd0;
   localparam logic [STEP_W-1:0] STEP_VERDICT = 4'd1;
   localparam logic [STEP_W-1:0] STEP_ACK_FIRST = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ACK_LAST = 4'd9;

   typedef struct packed {
      logic [BIT_SEL_W-1:0] data_bit;
      logic [BIT_SEL_W-1:0] seq_bit;
      logic [BIT_SEL_W-1:0] ack_bit;
      logic [BIT_SEL_W-1:0] ackno_bit;
   } cfg_type;

   // All results that one input word causes
   typedef struct packed {
      logic pay_valid;
      logic [BYTE_W-1:0] pay_byte;
      logic verdict_valid;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0] length;
      logic ack_number;
      logic ack_valid;
      logic [2*BYTE_W-1:0] reply_flags;
   } bundle_type;

endpackage

// ===== design/swpr_parser.sv =====
// Header capture, running checksum, byte count and verdict logic.
// Depends on swpr_pkg.
module swpr_parser
   import swpr_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic rx_last,
   input  cfg_type cfg,
   output bundle_type bundle,
   output logic has_result
);

   localparam int CW = $clog2(MAX_PACKET_BYTES + 2);

   logic [CW-1:0] count_ff, count_in, count_nx;
   logic [BYTE_W-1:0] even_ff, even_in, even_nx;
   logic [BYTE_W-1:0] odd_ff, odd_in, odd_nx;
   logic [15:0] flags_ff, flags_in, flags_nx;
   logic [15:0] check_ff, check_in, check_nx;
   logic [31:0] size_ff, size_in, size_nx;

   logic in_range, over, size_ok, sum_ok, seq, an;
   logic [CW-1:0] rcvd;
   logic [STATUS_W-1:0] st;

   always_comb begin
      count_nx = count_ff;
      even_nx = even_ff;
      odd_nx = odd_ff;
      flags_nx = flags_ff;
      check_nx = check_ff;
      size_nx = size_ff;
      in_range = count_ff < CW'(MAX_PACKET_BYTES);
      if (in_range) begin
         if (count_ff < CW'(FLAGS_END)) begin
            flags_nx = {flags_ff[7:0], rx_byte};
         end else if (count_ff < CW'(CHECK_END)) begin
            check_nx = {check_ff[7:0], rx_byte};
         end else if (count_ff < CW'(HDR_BYTES)) begin
            size_nx = {size_ff[23:0], rx_byte};
         end
         // leave the checksum word itself out of the sum
         if (!(count_ff >= CW'(FLAGS_END) && count_ff < CW'(CHECK_END))) begin
            if (count_ff[0]) begin
               odd_nx = odd_ff ^ rx_byte;
            end else begin
               even_nx = even_ff ^ rx_byte;
            end
         end
         count_nx = count_ff + CW'(1);
      end else begin
         count_nx = CW'(MAX_PACKET_BYTES + 1);
      end
   end

   always_comb begin
      over = count_nx > CW'(MAX_PACKET_BYTES);
      rcvd = over ? CW'(MAX_PACKET_BYTES) : count_nx;
      seq = flags_nx[cfg.seq_bit];
      size_ok = !over && (size_nx == 32'(rcvd));
      sum_ok = (even_nx == check_nx[15:8]) && (odd_nx == check_nx[7:0]);
      st = !size_ok ? ST_BAD_SIZE : (!sum_ok ? ST_BAD_CHECKSUM : ST_ACCEPTED);
      an = (st == ST_ACCEPTED) ? seq : !seq;

      bundle = '0;
      bundle.pay_valid = in_range && (count_ff >= CW'(HDR_BYTES));
      bundle.pay_byte = rx_byte;
      if (rx_last) begin
         bundle.verdict_valid = 1'b1;
         if (rcvd < CW'(HDR_BYTES)) begin
            bundle.status = ST_TOO_SHORT;
         end else if (!flags_nx[cfg.data_bit]) begin
            bundle.status = ST_NOT_DATA;
            bundle.length = LEN_W'(rcvd - CW'(HDR_BYTES));
         end else begin
            bundle.status = st;
            bundle.length = LEN_W'(rcvd - CW'(HDR_BYTES));
            bundle.ack_number = an;
            bundle.ack_valid = 1'b1;
            bundle.reply_flags = (16'd1 << cfg.ack_bit) | (16'(an) << cfg.ackno_bit);
         end
      end
      has_result = bundle.pay_valid || bundle.verdict_valid;
   end

   // clear the packet state after every last byte
   always_comb begin
      count_in = count_ff;
      even_in = even_ff;
      odd_in = odd_ff;
      flags_in = flags_ff;
      check_in = check_ff;
      size_in = size_ff;
      if (advance) begin
         if (rx_last) begin
            count_in = '0;
            even_in = '0;
            odd_in = '0;
            flags_in = '0;
            check_in = '0;
            size_in = '0;
         end else begin
            count_in = count_nx;
            even_in = even_nx;
            odd_in = odd_nx;
            flags_in = flags_nx;
            check_in = check_nx;
            size_in = size_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         even_ff <= '0;
         odd_ff <= '0;
         flags_ff <= '0;
         check_ff <= '0;
         size_ff <= '0;
      end else begin
         count_ff <= count_in;
         even_ff <= even_in;
         odd_ff <= odd_in;
         flags_ff <= flags_in;
         check_ff <= check_in;
         size_ff <= size_in;
      end
   end

endmodule

// ===== design/swpr_emitter.sv =====
// Result register and emit sequencer: walks a bundle out one word per cycle if rsp_tready.
// Depends on swpr_pkg.
module swpr_emitter
   import swpr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic load_en,
   input  bundle_type bundle,
   output logic free,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata, // out_byte, status, payload_length, ack_number
   output logic [KIND_W-1:0] rsp_tuser,     // out_kind
   output logic rsp_tlast                   // out_last
);

   logic busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in, step_next;
   bundle_type bnd_ff, bnd_in;
   logic step_last, fin;
   logic [2:0] ack_k;
   logic [BYTE_W-1:0] fh, fl, ob;
   logic [STATUS_W-1:0] ost;
   logic [LEN_W-1:0] olen;
   logic oan;

   always_comb begin
      step_last = 1'b0;
      step_next = step_ff + STEP_W'(1);
      case (step_ff)
         STEP_PAYLOAD: step_last = !bnd_ff.verdict_valid;
         STEP_VERDICT: step_last = !bnd_ff.ack_valid;
         STEP_ACK_LAST: step_last = 1'b1;
         default: step_last = 1'b0;
      endcase
      fin = busy_ff && rsp_tready && step_last;
      free = !busy_ff || fin;
   end

   always_comb begin
      ack_k = 3'(step_ff - STEP_ACK_FIRST);
      fh = bnd_ff.reply_flags[15:8];
      fl = bnd_ff.reply_flags[7:0];
      ob = '0;
      ost = ST_ACCEPTED;
      olen = '0;
      oan = 1'b0;
      rsp_tuser = KIND_ACK;
      case (step_ff)
         STEP_PAYLOAD: begin
            rsp_tuser = KIND_PAYLOAD;
            ob = bnd_ff.pay_byte;
         end
         STEP_VERDICT: begin
            rsp_tuser = KIND_VERDICT;
            ost = bnd_ff.status;
            olen = bnd_ff.length;
            oan = bnd_ff.ack_number;
         end
         default: begin
            case (ack_k)
               3'd0: ob = fh;
               3'd1: ob = fl;
               3'd2: ob = fh;
               3'd3: ob = fl ^ ACK_CHECK_FIX;
               3'd7: ob = ACK_SIZE_LOW;
               default: ob = '0;
            endcase
         end
      endcase
      rsp_tvalid = busy_ff;
      rsp_tlast = step_last;
      rsp_tdata = {2'b00, oan, olen, ost, ob};
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      bnd_in = bnd_ff;
      if (load_en) begin
         busy_in = 1'b1;
         bnd_in = bundle;
         step_in = bundle.pay_valid ? STEP_PAYLOAD : STEP_VERDICT;
      end else if (fin) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_tready) begin
         step_in = step_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_PAYLOAD;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      bnd_ff <= bnd_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_en |-> free)
      else $error("bundle loaded over one still being emitted");

   a_ack_has_verdict: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_tuser == KIND_ACK) |-> (bnd_ff.verdict_valid && bnd_ff.ack_valid))
      else $error("ack word emitted without a verdict");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (fin && !load_en) |=> !busy_ff)
      else $error("emitter still busy after the last word");

endmodule

// ===== design/stop_wait_packet_receiver.sv =====
// Stop-and-wait packet receiver, top level: input register, flag registers,
// parser and emitter. Depends on swpr_pkg, swpr_parser and swpr_emitter.
// A word accepted on req passes the input register, then the emitter result register, to rsp.
// Throughput: one byte per cycle while each byte gives at most one result and rsp_tready.
// A last byte gives a verdict and, for data packets, an 8-word ack: the
// emitter holds the input register until all of these words are sent.
// Reset (synchronous): clears packet state, flags to defaults; no clearing pass.
module stop_wait_packet_receiver
   import swpr_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
) (
   input  logic clock,
   input  logic reset,
   // input stream, one datagram byte per word
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [BYTE_W-1:0] req_tdata,      // rx_byte
   input  logic req_tlast,                   // rx_last
   // result stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_byte, status, payload_length, ack_number
   output logic [KIND_W-1:0] rsp_tuser,      // out_kind
   output logic rsp_tlast,                   // out_last
   // flag bit position registers
   input  logic csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BIT_SEL_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic in_last_ff, in_last_in;
   logic advance, free, has_result;
   bundle_type bundle;

   // The user must write the flag registers only while the block is idle; not enforced.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DATA_FLAG_BIT: cfg_in.data_bit = csr_wdata;
            REG_SEQ_FLAG_BIT: cfg_in.seq_bit = csr_wdata;
            REG_ACK_FLAG_BIT: cfg_in.ack_bit = csr_wdata;
            REG_ACKNO_FLAG_BIT: cfg_in.ackno_bit = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Advance the held word into the parser once the emitter can take its
   // results; header bytes without results advance without loading anything.
   assign advance = in_valid_ff && free;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      in_last_in = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in = req_tdata;
         in_last_in = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{data_bit: RST_DATA_FLAG_BIT, seq_bit: RST_SEQ_FLAG_BIT,
                     ack_bit: RST_ACK_FLAG_BIT, ackno_bit: RST_ACKNO_FLAG_BIT};
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   swpr_parser #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .rx_byte(in_byte_ff),
      .rx_last(in_last_ff),
      .cfg(cfg_ff),
      .bundle(bundle),
      .has_result(has_result)
   );

   swpr_emitter u_emitter (
      .clock(clock),
      .reset(reset),
      .load_en(advance && has_result),
      .bundle(bundle),
      .free(free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

endmodule
